>>> rtl/core/lru_assoc_cache_table_top_assert.svh
// Assertion macros for the LRU cache table top level.
`ifndef LRU_ASSOC_CACHE_TABLE_TOP_ASSERT_SVH
`define LRU_ASSOC_CACHE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk, masked while in reset.
`define LCT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, masked while in reset.
`define LCT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/lru_cache_pkg.sv
// Types, codes and widths shared by the LRU cache table.
`default_nettype none

package lru_cache_pkg;

	localparam int SLOTS_DEF = 16;

	localparam int CFG_W  = 5;
	localparam int FUNC_W = 2;
	localparam int KEY_W  = 31;
	localparam int VAL_W  = 32;
	localparam int AGE_W  = 64;
	localparam int OC_W   = 2;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 3;

	localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 5'd16;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INVAL = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

	// Put outcome codes
	localparam logic [OC_W-1:0] OC_UPDATE = 2'd0;
	localparam logic [OC_W-1:0] OC_FILL   = 2'd1;
	localparam logic [OC_W-1:0] OC_EVICT  = 2'd2;
	localparam logic [OC_W-1:0] OC_NONE   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} state_t;

	// One stored slot: key, value and age stamp
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		logic [AGE_W-1:0] age;
	} entry_t;

	localparam int ENTRY_W = KEY_W + VAL_W + AGE_W;

endpackage

`default_nettype wire

>>> rtl/core/lru_cache_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lru_cache_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/lru_assoc_cache_table_top.sv
// Get, put and invalidate run IDLE, a SCAN over the slots in use, LAST and DONE, then the output register.
// Unused code and zero-value put go from IDLE straight to DONE; they do not touch the table.
// A new item is accepted only in IDLE, after the serial scan over the slot RAM read port and DONE.
// The scan compares key, empty slot and oldest age for one slot per cycle in one shared unit.
// Reset clears all valid bits, the age counter and slots_in_use (16) at once; no clearing pass.
// A finished result waits in the output register while the next item is accepted.
`default_nettype none
`include "lru_assoc_cache_table_top_assert.svh"

module lru_assoc_cache_table_top
	import lru_cache_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration: slots_in_use
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_W-1:0]      cfg_wr_data,
	// Input beat
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // lookup_key[30:0], store_value[62:31], 0
	input  wire logic [FUNC_W-1:0]     s_axis_tuser,  // func[1:0]
	// Result beat
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // read_value[31:0]
	output logic [OUT_USER_W-1:0]      m_axis_tuser   // hit[0], put_outcome[2:1]
);

	state_t state_q, state_d;

	logic [CFG_W-1:0] slots_cfg_q;
	logic [IW-1:0]    n_last;

	logic [FUNC_W-1:0] func_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic              trivial_q;

	logic [SLOTS-1:0] valid_q;
	logic [AGE_W-1:0] age_q;
	logic [AGE_W-1:0] stamp;

	logic [IW-1:0] scan_idx_q;
	logic          chk_v_s1;
	logic [IW-1:0] chk_idx_s1;

	logic             match_found_q;
	logic [IW-1:0]    match_idx_q;
	logic [VAL_W-1:0] match_val_q;
	logic             empty_found_q;
	logic [IW-1:0]    empty_idx_q;
	logic [AGE_W-1:0] min_age_q;
	logic [IW-1:0]    min_idx_q;

	logic             rd_en;
	logic [ENTRY_W-1:0] rd_word;
	entry_t           rd_ent;
	logic             wr_en;
	logic [IW-1:0]    wr_idx;
	entry_t           wr_ent;
	logic             set_valid;
	logic             clr_valid;
	logic             bump_age;
	logic             advance;

	logic             res_hit;
	logic [VAL_W-1:0] res_val;
	logic [OC_W-1:0]  res_oc;

	logic             out_valid_q;
	logic             out_hit_q;
	logic [VAL_W-1:0] out_val_q;
	logic [OC_W-1:0]  out_oc_q;

	logic in_beat;

	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign stamp   = age_q + 64'd1;
	assign rd_ent  = entry_t'(rd_word);

	// Clamp the slot count to 1..SLOTS, kept as last index
	always_comb begin
		if (slots_cfg_q == '0) begin
			n_last = '0;
		end else if (32'(slots_cfg_q) > SLOTS) begin
			n_last = IW'(SLOTS - 1);
		end else begin
			n_last = IW'(slots_cfg_q - 5'd1);
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_cfg_q <= SLOTS_IN_USE_RST;
		end else if (cfg_wr_en) begin
			slots_cfg_q <= cfg_wr_data;
		end
	end

	// Slot storage: key, value, age
	lru_cache_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_idx),
		.wr_data(wr_ent),
		.rd_en  (rd_en),
		.rd_addr(scan_idx_q),
		.rd_data(rd_word)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, commit decision and result
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		advance       = 1'b0;
		wr_en         = 1'b0;
		wr_idx        = match_idx_q;
		wr_ent        = '{key: key_q, val: val_q, age: stamp};
		set_valid     = 1'b0;
		clr_valid     = 1'b0;
		bump_age      = 1'b0;
		res_hit       = 1'b0;
		res_val       = '0;
		res_oc        = OC_NONE;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if ((s_axis_tuser == FUNC_NOP) ||
					    ((s_axis_tuser == FUNC_PUT) && (s_axis_tdata[62:31] == '0))) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (scan_idx_q == n_last) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				advance = !out_valid_q || m_axis_tready;
				if (advance) begin
					state_d = ST_IDLE;
				end
				if (!trivial_q) begin
					case (func_q)
						FUNC_GET: begin
							if (match_found_q) begin
								res_hit  = 1'b1;
								res_val  = match_val_q;
								wr_en    = advance;
								wr_ent   = '{key: key_q, val: match_val_q, age: stamp};
								bump_age = advance;
							end
						end
						FUNC_PUT: begin
							wr_en    = advance;
							bump_age = advance;
							if (match_found_q) begin
								res_hit = 1'b1;
								res_oc  = OC_UPDATE;
							end else if (empty_found_q) begin
								wr_idx    = empty_idx_q;
								set_valid = advance;
								res_oc    = OC_FILL;
							end else begin
								wr_idx    = min_idx_q;
								set_valid = advance;
								res_oc    = OC_EVICT;
							end
						end
						FUNC_INVAL: begin
							if (match_found_q) begin
								res_hit   = 1'b1;
								clr_valid = advance;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Latch the input beat
	always_ff @(posedge clk) begin
		if (in_beat) begin
			func_q    <= s_axis_tuser;
			key_q     <= s_axis_tdata[30:0];
			val_q     <= s_axis_tdata[62:31];
			trivial_q <= (s_axis_tuser == FUNC_NOP) ||
			             ((s_axis_tuser == FUNC_PUT) && (s_axis_tdata[62:31] == '0));
		end
	end

	// Scan address and read-data tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			chk_v_s1   <= 1'b0;
			chk_idx_s1 <= '0;
		end else begin
			chk_v_s1   <= rd_en;
			chk_idx_s1 <= scan_idx_q;
			if (in_beat) begin
				scan_idx_q <= '0;
			end else if (rd_en) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	// Shared compare unit: key match, first empty, oldest age
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (in_beat) begin
			match_found_q <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (chk_v_s1) begin
			if (valid_q[chk_idx_s1] && (rd_ent.key == key_q) && !match_found_q) begin
				match_found_q <= 1'b1;
			end
			if (!valid_q[chk_idx_s1] && !empty_found_q) begin
				empty_found_q <= 1'b1;
			end
		end
	end

	// Indexes, value and age of the scan winners
	always_ff @(posedge clk) begin
		if (chk_v_s1) begin
			if (valid_q[chk_idx_s1] && (rd_ent.key == key_q) && !match_found_q) begin
				match_idx_q <= chk_idx_s1;
				match_val_q <= rd_ent.val;
			end
			if (!valid_q[chk_idx_s1] && !empty_found_q) begin
				empty_idx_q <= chk_idx_s1;
			end
			if ((chk_idx_s1 == '0) || (rd_ent.age < min_age_q)) begin
				min_age_q <= rd_ent.age;
				min_idx_q <= chk_idx_s1;
			end
		end
	end

	// Valid bits and age counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			age_q   <= '0;
		end else begin
			if (set_valid) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[match_idx_q] <= 1'b0;
			end
			if (bump_age) begin
				age_q <= stamp;
			end
		end
	end

	// Output register: hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_hit_q <= res_hit;
			out_val_q <= res_val;
			out_oc_q  <= res_oc;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tuser  = {out_oc_q, out_hit_q};

	// Checks
	`LCT_ASSERT_IMP(a_scan_bound, state_q == ST_SCAN, scan_idx_q <= n_last,
		"scan index past the slots in use")
	`LCT_ASSERT_NXT(a_beat_leaves_idle, in_beat, state_q != ST_IDLE,
		"input beat accepted but sequencer stayed idle")
	`LCT_ASSERT_IMP(a_fill_slot_empty, (state_q == ST_DONE) && empty_found_q,
		!valid_q[empty_idx_q], "slot chosen for fill is not empty")
	`LCT_ASSERT_IMP(a_update_is_hit, m_axis_tvalid && (m_axis_tuser[2:1] == OC_UPDATE),
		m_axis_tuser[0], "in-place update reported without a hit")

endmodule

`default_nettype wire

>>> tb/lru_cache_checker.sv
// Checker for the LRU cache table: mirrors the table, predicts each result beat and compares.
module lru_cache_checker
	import lru_cache_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_W-1:0]      cfg_wr_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // lookup_key[30:0], store_value[62:31], 0
	input  logic [FUNC_W-1:0]     s_axis_tuser,  // func[1:0]
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,  // read_value[31:0]
	input  logic [OUT_USER_W-1:0] m_axis_tuser,  // hit[0], put_outcome[2:1]
	output int                    mismatches,
	output int                    awaiting,
	output int                    hits,
	output int                    evictions
);

	typedef struct packed {
		logic              hit;
		logic [VAL_W-1:0]  read_value;
		logic [OC_W-1:0]   put_outcome;
	} lookup_result_t;

	lookup_result_t    lookup_results_q[$];

	// Mirror of the table and its age counter
	logic [CFG_W-1:0]  slots_cfg;
	logic              tag_valid [SLOTS_DEF];
	logic [KEY_W-1:0]  tag_key   [SLOTS_DEF];
	logic [VAL_W-1:0]  tag_value [SLOTS_DEF];
	logic [AGE_W-1:0]  tag_age   [SLOTS_DEF];
	logic [AGE_W-1:0]  age_stamp;

	function automatic int slots_searched();
		if (slots_cfg == 0)
			return 1;
		if (slots_cfg > SLOTS_DEF)
			return SLOTS_DEF;
		return int'(slots_cfg);
	endfunction

	function automatic int find_entry(logic [KEY_W-1:0] key, int n);
		for (int i = 0; i < n; i++)
			if (tag_valid[i] && tag_key[i] == key)
				return i;
		return -1;
	endfunction

	// Apply one operation to the mirror and work out the result it gives
	task automatic apply_cache_op(
		input  logic [FUNC_W-1:0] op,
		input  logic [KEY_W-1:0]  key,
		input  logic [VAL_W-1:0]  value,
		output lookup_result_t    res
	);
		int n;
		int s;
		n = slots_searched();
		res.hit = 1'b0;
		res.read_value = '0;
		res.put_outcome = OC_NONE;
		case (op)
			FUNC_GET: begin
				s = find_entry(key, n);
				if (s >= 0) begin
					age_stamp = age_stamp + 1'b1;
					tag_age[s] = age_stamp;
					res.hit = 1'b1;
					res.read_value = tag_value[s];
				end
			end
			FUNC_PUT: begin
				// A zero value is a null handle: skip the search entirely
				if (value != '0) begin
					s = find_entry(key, n);
					if (s >= 0) begin
						res.hit = 1'b1;
						res.put_outcome = OC_UPDATE;
					end else begin
						for (int i = 0; i < n; i++)
							if (s < 0 && !tag_valid[i])
								s = i;
						if (s >= 0) begin
							res.put_outcome = OC_FILL;
						end else begin
							// Oldest stamp wins, lowest index on a tie
							s = 0;
							for (int i = 1; i < n; i++)
								if (tag_age[i] < tag_age[s])
									s = i;
							res.put_outcome = OC_EVICT;
						end
						tag_key[s] = key;
						tag_valid[s] = 1'b1;
					end
					tag_value[s] = value;
					age_stamp = age_stamp + 1'b1;
					tag_age[s] = age_stamp;
				end
			end
			FUNC_INVAL: begin
				s = find_entry(key, n);
				if (s >= 0) begin
					tag_valid[s] = 1'b0;
					tag_key[s] = '0;
					tag_value[s] = '0;
					tag_age[s] = '0;
					res.hit = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		lookup_result_t exp_res;
		lookup_result_t got_res;
		if (!arst_n) begin
			// Clear the mirror the same way reset clears the table
			for (int i = 0; i < SLOTS_DEF; i++) begin
				tag_valid[i] = 1'b0;
				tag_key[i] = '0;
				tag_value[i] = '0;
				tag_age[i] = '0;
			end
			slots_cfg = SLOTS_IN_USE_RST;
			age_stamp = '0;
			lookup_results_q.delete();
			mismatches = 0;
			hits = 0;
			evictions = 0;
		end else begin
			// Compare a result beat with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got_res.hit = m_axis_tuser[0];
				got_res.put_outcome = m_axis_tuser[2:1];
				got_res.read_value = m_axis_tdata;
				if (lookup_results_q.size() == 0) begin
					$error("result beat with no operation pending");
					mismatches++;
				end else begin
					exp_res = lookup_results_q.pop_front();
					if (got_res.hit !== exp_res.hit) begin
						$error("hit: expected %0d, actual %0d", exp_res.hit, got_res.hit);
						mismatches++;
					end
					if (got_res.read_value !== exp_res.read_value) begin
						$error("read_value: expected %08h, actual %08h",
							exp_res.read_value, got_res.read_value);
						mismatches++;
					end
					if (got_res.put_outcome !== exp_res.put_outcome) begin
						$error("put_outcome: expected %0d, actual %0d",
							exp_res.put_outcome, got_res.put_outcome);
						mismatches++;
					end
					if (exp_res.hit)
						hits++;
					if (exp_res.put_outcome == OC_EVICT)
						evictions++;
				end
			end
			if (cfg_wr_en)
				slots_cfg = cfg_wr_data;
			// Predict the result of an accepted operation beat
			if (s_axis_tvalid && s_axis_tready) begin
				apply_cache_op(s_axis_tuser, s_axis_tdata[KEY_W-1:0],
					s_axis_tdata[KEY_W+VAL_W-1:KEY_W], exp_res);
				lookup_results_q.push_back(exp_res);
			end
		end
		awaiting = lookup_results_q.size();
	end

endmodule

>>> tb/lru_assoc_cache_table_top_test.sv
// Testbench top for the LRU cache table: clock, reset, operation stimulus and verdict.
module lru_assoc_cache_table_top_test;
	import lru_cache_pkg::*;

	localparam int RUN_LIMIT       = 600000;
	localparam int LONG_HOLD       = 600;
	localparam int DRAIN_CYCLES    = 40;
	localparam int ITEMS_PER_PHASE = 73;
	localparam int POOL_MAX        = 40;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]      cfg_wr_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	wire                   s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // lookup_key[30:0], store_value[62:31], 0
	logic [FUNC_W-1:0]     s_axis_tuser = '0;   // func[1:0]
	wire                   m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	wire [OUT_DATA_W-1:0]  m_axis_tdata;        // read_value[31:0]
	wire [OUT_USER_W-1:0]  m_axis_tuser;        // hit[0], put_outcome[2:1]

	int mismatches;
	int awaiting;
	int hit_total;
	int evict_total;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int ops_sent = 0;
	int settings_used = 0;

	logic [KEY_W-1:0] key_pool [POOL_MAX];
	int pool_size;

	lru_assoc_cache_table_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	lru_cache_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.awaiting      (awaiting),
		.hits          (hit_total),
		.evictions     (evict_total)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Drive result-side ready: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Offer one operation beat, with random idle cycles first, and wait for acceptance
	task automatic send_op(
		input logic [FUNC_W-1:0] op,
		input logic [KEY_W-1:0]  key,
		input logic [VAL_W-1:0]  value
	);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, value, key};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		ops_sent++;
	endtask

	// Stop offering and wait until every predicted result has come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
	endtask

	task automatic set_slots(input logic [CFG_W-1:0] n);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Random operations over a key pool a little larger than the slots in use
	task automatic random_phase(
		input logic [CFG_W-1:0] n,
		input int               src_pct,
		input int               sink_pct,
		input bit               long_hold
	);
		int eff;
		int r;
		logic [VAL_W-1:0]  value;
		logic [FUNC_W-1:0] op;
		set_slots(n);
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		eff = (n == 0) ? 1 : (n > SLOTS_DEF) ? SLOTS_DEF : int'(n);
		pool_size = eff + 1 + $urandom_range(eff + 2);
		if (pool_size > POOL_MAX)
			pool_size = POOL_MAX;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_MAX; i++)
			key_pool[i] = KEY_W'($urandom);
		if (long_hold)
			hold_req = hold_req + 1;
		repeat (ITEMS_PER_PHASE) begin
			r = $urandom_range(99);
			op = (r < 40) ? FUNC_GET : (r < 80) ? FUNC_PUT : (r < 92) ? FUNC_INVAL : FUNC_NOP;
			r = $urandom_range(9);
			value = (r == 0) ? '0 : (r == 1) ? '1 : VAL_W'($urandom);
			send_op(op, key_pool[$urandom_range(pool_size - 1)], value);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: miss, fill, hit, update, null put, unused code, invalidate
		send_op(FUNC_GET,   31'd0,          32'd0);
		send_op(FUNC_PUT,   31'd0,          32'hFFFF_FFFF);
		send_op(FUNC_GET,   31'd0,          32'd0);
		send_op(FUNC_PUT,   31'h7FFF_FFFF,  32'd1);
		send_op(FUNC_PUT,   31'd0,          32'd5);
		send_op(FUNC_GET,   31'd0,          32'hFFFF_FFFF);
		send_op(FUNC_PUT,   31'd123,        32'd0);
		send_op(FUNC_NOP,   31'h7FFF_FFFF,  32'hFFFF_FFFF);
		send_op(FUNC_INVAL, 31'd0,          32'd0);
		send_op(FUNC_INVAL, 31'd0,          32'd0);
		send_op(FUNC_GET,   31'd0,          32'd0);
		send_op(FUNC_GET,   31'h7FFF_FFFF,  32'd0);

		// Directed: two slots, so puts of new keys evict the least recently used
		set_slots(5'd2);
		send_op(FUNC_PUT,   31'd10,         32'hA5A5_0001);
		send_op(FUNC_PUT,   31'd11,         32'h5A5A_0002);
		send_op(FUNC_GET,   31'd10,         32'd0);
		send_op(FUNC_PUT,   31'd12,         32'h0000_0003);
		send_op(FUNC_GET,   31'd11,         32'd0);
		send_op(FUNC_GET,   31'd10,         32'd0);
		send_op(FUNC_PUT,   31'd13,         32'h8000_0000);
		send_op(FUNC_GET,   31'd12,         32'd0);

		// Random phases over slot counts and idling mixes
		random_phase(5'd16, 0,  0,  1'b1);
		random_phase(5'd1,  86, 0,  1'b0);
		random_phase(5'd0,  0,  86, 1'b0);
		random_phase(5'd31, 6,  6,  1'b0);
		random_phase(5'd4,  0,  0,  1'b0);
		random_phase(5'd2,  86, 0,  1'b0);
		random_phase(5'd16, 0,  86, 1'b0);
		random_phase(5'd8,  6,  6,  1'b0);
		random_phase(5'd3,  0,  0,  1'b0);
		random_phase(5'd16, 86, 0,  1'b0);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d operations over %0d slot settings, four idling mixes and a long stall.",
			ops_sent, settings_used);
		$display("Results with a hit: %0d, evictions: %0d.", hit_total, evict_total);
		if (mismatches == 0 && awaiting == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> lru_assoc_cache_table_top.f
+incdir+rtl/core
rtl/core/lru_cache_pkg.sv
rtl/core/lru_cache_ram.sv
rtl/core/lru_assoc_cache_table_top.sv
tb/lru_cache_checker.sv
tb/lru_assoc_cache_table_top_test.sv
